@@ design/roe_average_eigenvectors_unit_assert.svh @@
// ----------------------------------------------------------------------------
// roe average eigenvectors assertion macros
// checks written with these expect clk and rst_n in scope
// ----------------------------------------------------------------------------
`ifndef ROE_AVERAGE_EIGENVECTORS_UNIT_ASSERT_SVH
`define ROE_AVERAGE_EIGENVECTORS_UNIT_ASSERT_SVH

// same-cycle implication
`define ROE_AVG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ROE_AVG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/roe_avg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roe_avg_pkg
// shared types and constants of the roe average eigenvector unit
// ----------------------------------------------------------------------------
package roe_avg_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int WORD_BITS_DEF     = 32;

    localparam int               HEAT_RATIO_BITS  = 18;
    localparam logic [17:0]      HEAT_RATIO_RESET = 18'd91750;
    localparam logic [1:0]       ROW_LAST         = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_OUTER  = 2'd1,
        CMD_MIDDLE = 2'd2,
        CMD_FULL   = 2'd3
    } roe_avg_cmd_t;

    typedef enum logic [1:0] {
        UNIT_NONE,
        UNIT_MUL,
        UNIT_DIV,
        UNIT_ROOT
    } roe_avg_unit_t;

    // one strobe per shared unit
    typedef struct packed {
        logic mul;
        logic div;
        logic root;
    } roe_avg_strobe_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SR, ST_H, ST_D1, ST_D2, ST_SS, ST_AR, ST_A1, ST_A2,
        ST_B1, ST_B2, ST_UU, ST_HU, ST_Y, ST_C, ST_ONEA, ST_K1, ST_K2,
        ST_XP, ST_XPU, ST_XPUU, ST_UOA, ST_ATU, ST_HX, ST_HO, ST_HOA,
        ST_HAV, ST_R7, ST_WR, ST_OUT
    } roe_avg_state_t;

endpackage

@@ design/roe_avg_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roe_avg_mul
// two-stage saturating fixed point multiplier, truncates magnitude
// ----------------------------------------------------------------------------
module roe_avg_mul #(
    parameter int FRACTION_BITS = roe_avg_pkg::FRACTION_BITS_DEF,
    parameter int WORD_BITS     = roe_avg_pkg::WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [WORD_BITS-1:0] a,
    input  logic signed [WORD_BITS-1:0] b,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] prod
);
    localparam int W = WORD_BITS;
    localparam logic [W-1:0] WMAX_U = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN_U = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]   mag_a, mag_b;
    logic [2*W-1:0] prod_reg, prod_next, shifted;
    logic           neg_reg, neg_next, stage_reg, stage_next, done_reg, done_next;
    logic [W-1:0]   res_reg, res_next;

    assign mag_a   = a[W-1] ? (~a + 1'b1) : a;
    assign mag_b   = b[W-1] ? (~b + 1'b1) : b;
    assign shifted = prod_reg >> FRACTION_BITS;

    always_comb
    begin
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        stage_next = start;
        done_next  = stage_reg;
        if (start)
        begin
            prod_next = mag_a * mag_b;
            neg_next  = a[W-1] ^ b[W-1];
        end
        if (stage_reg)
        begin
            if (neg_reg)
                res_next = (shifted > (2*W)'(WMIN_U)) ? WMIN_U : (~shifted[W-1:0] + 1'b1);
            else
                res_next = (shifted > (2*W)'(WMAX_U)) ? WMAX_U : shifted[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign prod = res_reg;

endmodule

@@ design/roe_avg_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roe_avg_div
// radix-2 restoring fixed point divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module roe_avg_div #(
    parameter int FRACTION_BITS = roe_avg_pkg::FRACTION_BITS_DEF,
    parameter int WORD_BITS     = roe_avg_pkg::WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [WORD_BITS-1:0] a,
    input  logic signed [WORD_BITS-1:0] b,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] quo
);
    localparam int W  = WORD_BITS;
    localparam int XW = WORD_BITS + FRACTION_BITS;
    localparam int CW = $clog2(XW + 1);
    localparam logic [W-1:0] WMAX_U = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN_U = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]  mag_a, mag_b;
    logic [XW-1:0] dvd_reg, dvd_next, q_reg, q_next, q_step;
    logic [W:0]    rem_reg, rem_next, sh;
    logic [W-1:0]  mb_reg, mb_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next, neg_reg, neg_next, ge;
    logic [W-1:0]  res_reg, res_next;

    assign mag_a  = a[W-1] ? (~a + 1'b1) : a;
    assign mag_b  = b[W-1] ? (~b + 1'b1) : b;
    assign sh     = {rem_reg[W-1:0], dvd_reg[XW-1]};
    assign ge     = sh >= {1'b0, mb_reg};
    assign q_step = {q_reg[XW-2:0], ge};

    always_comb
    begin
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        mb_next   = mb_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        if (start)
        begin
            if (b == '0)
            begin
                // divide by zero saturates toward the dividend sign
                res_next  = a[W-1] ? WMIN_U : WMAX_U;
                done_next = 1'b1;
            end
            else
            begin
                dvd_next  = XW'(mag_a) << FRACTION_BITS;
                mb_next   = mag_b;
                rem_next  = '0;
                q_next    = '0;
                neg_next  = a[W-1] ^ b[W-1];
                cnt_next  = CW'(XW);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (sh - {1'b0, mb_reg}) : sh;
            q_next   = q_step;
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                    res_next = (q_step > XW'(WMIN_U)) ? WMIN_U : (~q_step[W-1:0] + 1'b1);
                else
                    res_next = (q_step > XW'(WMAX_U)) ? WMAX_U : q_step[W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign quo  = res_reg;

endmodule

@@ design/roe_avg_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roe_avg_sqrt
// digit-by-digit fixed point square root, one root bit per cycle
// ----------------------------------------------------------------------------
module roe_avg_sqrt #(
    parameter int FRACTION_BITS = roe_avg_pkg::FRACTION_BITS_DEF,
    parameter int WORD_BITS     = roe_avg_pkg::WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [WORD_BITS-1:0] x,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] root
);
    localparam int W  = WORD_BITS;
    localparam int XW = WORD_BITS + FRACTION_BITS;
    localparam int RW = XW + (XW % 2);
    localparam int N  = RW / 2;
    localparam int CW = $clog2(N + 1);
    localparam logic [W-1:0] WMAX_U = {1'b0, {(W-1){1'b1}}};

    logic [RW-1:0] rad_reg, rad_next;
    logic [N+1:0]  rem_reg, rem_next, sh, trial;
    logic [N-1:0]  rt_reg, rt_next, rt_step;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next, ge;
    logic [W-1:0]  res_reg, res_next;

    assign sh      = {rem_reg[N-1:0], rad_reg[RW-1 -: 2]};
    assign trial   = {rt_reg, 2'b01};
    assign ge      = sh >= trial;
    assign rt_step = {rt_reg[N-2:0], ge};

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        rt_next   = rt_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        if (start)
        begin
            if (x[W-1] || (x == '0))
            begin
                // non-positive argument gives a zero root
                res_next  = '0;
                done_next = 1'b1;
            end
            else
            begin
                rad_next  = RW'($unsigned(x)) << FRACTION_BITS;
                rem_next  = '0;
                rt_next   = '0;
                cnt_next  = CW'(N);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (sh - trial) : sh;
            rt_next  = rt_step;
            rad_next = rad_reg << 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = ((N+W)'(rt_step) > (N+W)'(WMAX_U)) ? WMAX_U : W'(rt_step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        rt_reg  <= rt_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;

endmodule

@@ design/roe_average_eigenvectors_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roe_average_eigenvectors_unit
// roe averages and characteristic matrices of the 1d euler equations
// ----------------------------------------------------------------------------
// Cells enter left to right as signed fixed point words (Q16.16 by default).
// A load word stores the left cell and gives no result; every other word
// pairs the stored cell with the new one, forms the roe averages, updates
// the outer rows, the middle row or all of the 3x3 left and right
// eigenvector matrices, and then sends three row words, rows 0 to 2, the
// last one flagged by last_row. One cell is in flight at a time: in_ready
// is high only when idle. A pair walks a sequencer over one shared
// multiplier, one radix-2 divider and one digit-serial square root:
// two roots, five divisions and about twenty products, plus the three row
// transfers; a load runs only the first root and division. heat_ratio is
// taken only while the unit is idle and no cell is offered on the input.
// ----------------------------------------------------------------------------
`include "roe_average_eigenvectors_unit_assert.svh"

module roe_average_eigenvectors_unit #(
    parameter int FRACTION_BITS = roe_avg_pkg::FRACTION_BITS_DEF,
    parameter int WORD_BITS     = roe_avg_pkg::WORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // config write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [17:0]        heat_ratio,
    // cell input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic [30:0]        density,
    input  logic signed [31:0] velocity,
    input  logic [30:0]        pressure,
    input  logic [30:0]        energy,
    // row output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         row_index,
    output logic signed [31:0] left_col0,
    output logic signed [31:0] left_col1,
    output logic signed [31:0] left_col2,
    output logic signed [31:0] right_col0,
    output logic signed [31:0] right_col1,
    output logic signed [31:0] right_col2,
    output logic [30:0]        avg_density,
    output logic signed [31:0] avg_enthalpy,
    output logic signed [31:0] avg_velocity,
    output logic [30:0]        avg_sound_speed,
    output logic               last_row
);
    localparam int W = WORD_BITS;
    localparam int F = FRACTION_BITS;
    localparam int HRB = roe_avg_pkg::HEAT_RATIO_BITS;

    typedef logic signed [W-1:0] word_t;

    localparam word_t WMAX    = {1'b0, {(W-1){1'b1}}};
    localparam word_t WMIN    = {1'b1, {(W-1){1'b0}}};
    localparam word_t ONE     = W'(64'd1 << F);
    localparam word_t HALF    = W'(64'd1 << (F - 1));
    localparam word_t QUARTER = W'(64'd1 << (F - 2));

    // saturating word arithmetic
    function automatic word_t qadd(input word_t a, input word_t b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            qadd = s[W] ? WMIN : WMAX;
        else
            qadd = s[W-1:0];
    endfunction

    function automatic word_t qneg(input word_t a);
        qneg = (a == WMIN) ? WMAX : -a;
    endfunction

    function automatic word_t qsub(input word_t a, input word_t b);
        qsub = qadd(a, qneg(b));
    endfunction

    function automatic word_t sat_in(input logic signed [32:0] v);
        logic signed [65:0] vv, hi, lo;
        vv = v;
        hi = WMAX;
        lo = WMIN;
        if (vv > hi)
            sat_in = WMAX;
        else if (vv < lo)
            sat_in = WMIN;
        else
            sat_in = vv[W-1:0];
    endfunction

    function automatic logic [31:0] out_s32(input word_t v);
        logic signed [65:0] vv;
        vv = v;
        if (vv > 66'sd2147483647)
            out_s32 = 32'h7fff_ffff;
        else if (vv < -66'sd2147483648)
            out_s32 = 32'h8000_0000;
        else
            out_s32 = vv[31:0];
    endfunction

    function automatic logic [30:0] out_u31(input word_t v);
        logic signed [65:0] vv;
        vv = v;
        if (vv > 66'sd2147483647)
            out_u31 = 31'h7fff_ffff;
        else if (vv < 66'sd0)
            out_u31 = '0;
        else
            out_u31 = vv[30:0];
    endfunction

    roe_avg_pkg::roe_avg_state_t state_reg, state_next;
    roe_avg_pkg::roe_avg_cmd_t   cmd_reg, cmd_next;
    roe_avg_pkg::roe_avg_unit_t  unit_sel;
    roe_avg_pkg::roe_avg_strobe_t go_s, done_s;

    logic         wait_reg, wait_next;
    logic [1:0]   row_reg, row_next;
    logic [HRB-1:0] hr_reg;

    // latched cell
    word_t rho_reg, rho_next, u_reg, u_next, p_reg, p_next, e_reg, e_next;
    // stored left cell
    word_t psd_reg, psd_next, ph_reg, ph_next, pu_reg, pu_next;
    // intermediate results
    word_t sr_reg, sr_next, h_reg, h_next, d1_reg, d1_next, d2_reg, d2_next;
    word_t t0_reg, t0_next, avrho_reg, avrho_next, avh_reg, avh_next;
    word_t avu_reg, avu_next, ava_reg, ava_next, onea_reg, onea_next;
    word_t xp_reg, xp_next, xpu_reg, xpu_next, xpuu_reg, xpuu_next;
    word_t uoa_reg, uoa_next, atu_reg, atu_next, hx_reg, hx_next;
    word_t ho_reg, ho_next, hoa_reg, hoa_next, r7_reg, r7_next;
    // eigenvector matrices, row major
    word_t lm_reg [9];
    word_t lm_next [9];
    word_t rm_reg [9];
    word_t rm_next [9];

    word_t mul_a, mul_b, div_a, div_b, root_x;
    word_t mul_res, div_res, root_res, res_w;
    word_t g_w, gm1_w, s_w;
    word_t l0_w, l1_w, l2_w, r0_w, r1_w, r2_w;
    logic  res_ok;

    roe_avg_mul #(.FRACTION_BITS(FRACTION_BITS), .WORD_BITS(WORD_BITS)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(go_s.mul), .a(mul_a), .b(mul_b),
        .done(done_s.mul), .prod(mul_res)
    );

    roe_avg_div #(.FRACTION_BITS(FRACTION_BITS), .WORD_BITS(WORD_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(go_s.div), .a(div_a), .b(div_b),
        .done(done_s.div), .quo(div_res)
    );

    roe_avg_sqrt #(.FRACTION_BITS(FRACTION_BITS), .WORD_BITS(WORD_BITS)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(go_s.root), .x(root_x),
        .done(done_s.root), .root(root_res)
    );

    // only the unit launched by the current step can report back
    assign res_ok = done_s.mul | done_s.div | done_s.root;
    assign res_w  = done_s.mul ? mul_res : (done_s.div ? div_res : root_res);

    assign g_w   = {{(W-HRB){1'b0}}, hr_reg};
    assign gm1_w = qsub(g_w, ONE);
    // sum of root densities, old left cell stays until the sound speed is done
    assign s_w   = qadd(psd_reg, sr_reg);

    // config register, taken only when no cell is in flight or offered
    assign cfg_ready = (state_reg == roe_avg_pkg::ST_IDLE) && !in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hr_reg <= roe_avg_pkg::HEAT_RATIO_RESET;
        else if (cfg_valid && cfg_ready)
            hr_reg <= heat_ratio;
    end

    // sequencer: each step names a unit, its operands and where the result goes
    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        row_next   = row_reg;
        cmd_next   = cmd_reg;
        rho_next   = rho_reg;
        u_next     = u_reg;
        p_next     = p_reg;
        e_next     = e_reg;
        psd_next   = psd_reg;
        ph_next    = ph_reg;
        pu_next    = pu_reg;
        sr_next    = sr_reg;
        h_next     = h_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        t0_next    = t0_reg;
        avrho_next = avrho_reg;
        avh_next   = avh_reg;
        avu_next   = avu_reg;
        ava_next   = ava_reg;
        onea_next  = onea_reg;
        xp_next    = xp_reg;
        xpu_next   = xpu_reg;
        xpuu_next  = xpuu_reg;
        uoa_next   = uoa_reg;
        atu_next   = atu_reg;
        hx_next    = hx_reg;
        ho_next    = ho_reg;
        hoa_next   = hoa_reg;
        r7_next    = r7_reg;
        lm_next    = lm_reg;
        rm_next    = rm_reg;
        unit_sel   = roe_avg_pkg::UNIT_NONE;
        mul_a      = '0;
        mul_b      = '0;
        div_a      = '0;
        div_b      = '0;
        root_x     = '0;

        case (state_reg)
            roe_avg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = roe_avg_pkg::roe_avg_cmd_t'(command);
                    rho_next   = sat_in({2'b00, density});
                    u_next     = sat_in({velocity[31], velocity});
                    p_next     = sat_in({2'b00, pressure});
                    e_next     = sat_in({2'b00, energy});
                    state_next = roe_avg_pkg::ST_SR;
                end
            end
            roe_avg_pkg::ST_SR:
            begin
                unit_sel = roe_avg_pkg::UNIT_ROOT;
                root_x   = rho_reg;
                if (res_ok)
                begin
                    sr_next    = res_w;
                    state_next = roe_avg_pkg::ST_H;
                end
            end
            roe_avg_pkg::ST_H:
            begin
                unit_sel = roe_avg_pkg::UNIT_DIV;
                div_a    = qadd(e_reg, p_reg);
                div_b    = rho_reg;
                if (res_ok)
                begin
                    h_next = res_w;
                    if (cmd_reg == roe_avg_pkg::CMD_LOAD)
                    begin
                        psd_next   = sr_reg;
                        ph_next    = res_w;
                        pu_next    = u_reg;
                        state_next = roe_avg_pkg::ST_IDLE;
                    end
                    else
                        state_next = roe_avg_pkg::ST_D1;
                end
            end
            roe_avg_pkg::ST_D1:
            begin
                unit_sel = roe_avg_pkg::UNIT_DIV;
                div_a    = psd_reg;
                div_b    = s_w;
                if (res_ok)
                begin
                    d1_next    = res_w;
                    state_next = roe_avg_pkg::ST_D2;
                end
            end
            roe_avg_pkg::ST_D2:
            begin
                unit_sel = roe_avg_pkg::UNIT_DIV;
                div_a    = sr_reg;
                div_b    = s_w;
                if (res_ok)
                begin
                    d2_next    = res_w;
                    state_next = roe_avg_pkg::ST_SS;
                end
            end
            roe_avg_pkg::ST_SS:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = s_w;
                mul_b    = s_w;
                if (res_ok)
                begin
                    t0_next    = res_w;
                    state_next = roe_avg_pkg::ST_AR;
                end
            end
            roe_avg_pkg::ST_AR:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = t0_reg;
                mul_b    = QUARTER;
                if (res_ok)
                begin
                    avrho_next = res_w;
                    state_next = roe_avg_pkg::ST_A1;
                end
            end
            roe_avg_pkg::ST_A1:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = d1_reg;
                mul_b    = ph_reg;
                if (res_ok)
                begin
                    t0_next    = res_w;
                    state_next = roe_avg_pkg::ST_A2;
                end
            end
            roe_avg_pkg::ST_A2:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = d2_reg;
                mul_b    = h_reg;
                if (res_ok)
                begin
                    avh_next   = qadd(t0_reg, res_w);
                    state_next = roe_avg_pkg::ST_B1;
                end
            end
            roe_avg_pkg::ST_B1:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = d1_reg;
                mul_b    = pu_reg;
                if (res_ok)
                begin
                    t0_next    = res_w;
                    state_next = roe_avg_pkg::ST_B2;
                end
            end
            roe_avg_pkg::ST_B2:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = d2_reg;
                mul_b    = u_reg;
                if (res_ok)
                begin
                    avu_next   = qadd(t0_reg, res_w);
                    state_next = roe_avg_pkg::ST_UU;
                end
            end
            roe_avg_pkg::ST_UU:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = avu_reg;
                mul_b    = avu_reg;
                if (res_ok)
                begin
                    t0_next    = res_w;
                    state_next = roe_avg_pkg::ST_HU;
                end
            end
            roe_avg_pkg::ST_HU:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = HALF;
                mul_b    = t0_reg;
                if (res_ok)
                begin
                    t0_next    = res_w;
                    state_next = roe_avg_pkg::ST_Y;
                end
            end
            roe_avg_pkg::ST_Y:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = qsub(avh_reg, t0_reg);
                mul_b    = gm1_w;
                if (res_ok)
                begin
                    t0_next    = res_w;
                    state_next = roe_avg_pkg::ST_C;
                end
            end
            roe_avg_pkg::ST_C:
            begin
                unit_sel = roe_avg_pkg::UNIT_ROOT;
                root_x   = t0_reg;
                if (res_ok)
                begin
                    ava_next   = res_w;
                    // new cell becomes the left cell
                    psd_next   = sr_reg;
                    ph_next    = h_reg;
                    pu_next    = u_reg;
                    state_next = roe_avg_pkg::ST_ONEA;
                end
            end
            roe_avg_pkg::ST_ONEA:
            begin
                unit_sel = roe_avg_pkg::UNIT_DIV;
                div_a    = ONE;
                div_b    = ava_reg;
                if (res_ok)
                begin
                    onea_next  = res_w;
                    state_next = roe_avg_pkg::ST_K1;
                end
            end
            roe_avg_pkg::ST_K1:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = HALF;
                mul_b    = gm1_w;
                if (res_ok)
                begin
                    t0_next    = res_w;
                    state_next = roe_avg_pkg::ST_K2;
                end
            end
            roe_avg_pkg::ST_K2:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = t0_reg;
                mul_b    = onea_reg;
                if (res_ok)
                begin
                    t0_next    = res_w;
                    state_next = roe_avg_pkg::ST_XP;
                end
            end
            roe_avg_pkg::ST_XP:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = t0_reg;
                mul_b    = onea_reg;
                if (res_ok)
                begin
                    xp_next    = res_w;
                    state_next = roe_avg_pkg::ST_XPU;
                end
            end
            roe_avg_pkg::ST_XPU:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = xp_reg;
                mul_b    = avu_reg;
                if (res_ok)
                begin
                    xpu_next   = res_w;
                    state_next = roe_avg_pkg::ST_XPUU;
                end
            end
            roe_avg_pkg::ST_XPUU:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = xpu_reg;
                mul_b    = avu_reg;
                if (res_ok)
                begin
                    xpuu_next  = res_w;
                    state_next = roe_avg_pkg::ST_UOA;
                end
            end
            roe_avg_pkg::ST_UOA:
            begin
                unit_sel = roe_avg_pkg::UNIT_DIV;
                div_a    = avu_reg;
                div_b    = ava_reg;
                if (res_ok)
                begin
                    uoa_next   = res_w;
                    state_next = roe_avg_pkg::ST_ATU;
                end
            end
            roe_avg_pkg::ST_ATU:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = ava_reg;
                mul_b    = avu_reg;
                if (res_ok)
                begin
                    atu_next   = res_w;
                    state_next = roe_avg_pkg::ST_HX;
                end
            end
            roe_avg_pkg::ST_HX:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = HALF;
                mul_b    = xpuu_reg;
                if (res_ok)
                begin
                    hx_next    = res_w;
                    state_next = roe_avg_pkg::ST_HO;
                end
            end
            roe_avg_pkg::ST_HO:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = HALF;
                mul_b    = uoa_reg;
                if (res_ok)
                begin
                    ho_next    = res_w;
                    state_next = roe_avg_pkg::ST_HOA;
                end
            end
            roe_avg_pkg::ST_HOA:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = HALF;
                mul_b    = onea_reg;
                if (res_ok)
                begin
                    hoa_next   = res_w;
                    state_next = roe_avg_pkg::ST_HAV;
                end
            end
            roe_avg_pkg::ST_HAV:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = HALF;
                mul_b    = avu_reg;
                if (res_ok)
                begin
                    t0_next    = res_w;
                    state_next = roe_avg_pkg::ST_R7;
                end
            end
            roe_avg_pkg::ST_R7:
            begin
                unit_sel = roe_avg_pkg::UNIT_MUL;
                mul_a    = t0_reg;
                mul_b    = avu_reg;
                if (res_ok)
                begin
                    r7_next    = res_w;
                    state_next = roe_avg_pkg::ST_WR;
                end
            end
            roe_avg_pkg::ST_WR:
            begin
                if (cmd_reg == roe_avg_pkg::CMD_OUTER || cmd_reg == roe_avg_pkg::CMD_FULL)
                begin
                    lm_next[0] = qadd(hx_reg, ho_reg);
                    lm_next[1] = qsub(qneg(xpu_reg), hoa_reg);
                    lm_next[2] = xp_reg;
                    lm_next[6] = qsub(hx_reg, ho_reg);
                    lm_next[7] = qadd(qneg(xpu_reg), hoa_reg);
                    lm_next[8] = xp_reg;
                    rm_next[0] = ONE;
                    rm_next[2] = ONE;
                    rm_next[3] = qsub(avu_reg, ava_reg);
                    rm_next[5] = qadd(avu_reg, ava_reg);
                    rm_next[6] = qsub(avh_reg, atu_reg);
                    rm_next[8] = qadd(avh_reg, atu_reg);
                end
                if (cmd_reg == roe_avg_pkg::CMD_MIDDLE || cmd_reg == roe_avg_pkg::CMD_FULL)
                begin
                    lm_next[3] = qsub(ONE, xpuu_reg);
                    lm_next[4] = qadd(xpu_reg, xpu_reg);
                    lm_next[5] = qneg(qadd(xp_reg, xp_reg));
                end
                if (cmd_reg == roe_avg_pkg::CMD_FULL)
                begin
                    rm_next[1] = ONE;
                    rm_next[4] = avu_reg;
                    rm_next[7] = r7_reg;
                end
                row_next   = '0;
                state_next = roe_avg_pkg::ST_OUT;
            end
            roe_avg_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    if (row_reg == roe_avg_pkg::ROW_LAST)
                    begin
                        row_next   = '0;
                        state_next = roe_avg_pkg::ST_IDLE;
                    end
                    else
                        row_next = row_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = roe_avg_pkg::ST_IDLE;
            end
        endcase

        // launch once per step, hold off until the unit answers
        go_s      = '0;
        go_s.mul  = (unit_sel == roe_avg_pkg::UNIT_MUL) && !wait_reg;
        go_s.div  = (unit_sel == roe_avg_pkg::UNIT_DIV) && !wait_reg;
        go_s.root = (unit_sel == roe_avg_pkg::UNIT_ROOT) && !wait_reg;
        if (unit_sel != roe_avg_pkg::UNIT_NONE)
            wait_next = !res_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= roe_avg_pkg::ST_IDLE;
            wait_reg  <= 1'b0;
            row_reg   <= '0;
            psd_reg   <= '0;
            ph_reg    <= '0;
            pu_reg    <= '0;
            lm_reg    <= '{default: '0};
            rm_reg    <= '{default: '0};
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            row_reg   <= row_next;
            psd_reg   <= psd_next;
            ph_reg    <= ph_next;
            pu_reg    <= pu_next;
            lm_reg    <= lm_next;
            rm_reg    <= rm_next;
        end
    end

    // datapath words, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        rho_reg   <= rho_next;
        u_reg     <= u_next;
        p_reg     <= p_next;
        e_reg     <= e_next;
        sr_reg    <= sr_next;
        h_reg     <= h_next;
        d1_reg    <= d1_next;
        d2_reg    <= d2_next;
        t0_reg    <= t0_next;
        avrho_reg <= avrho_next;
        avh_reg   <= avh_next;
        avu_reg   <= avu_next;
        ava_reg   <= ava_next;
        onea_reg  <= onea_next;
        xp_reg    <= xp_next;
        xpu_reg   <= xpu_next;
        xpuu_reg  <= xpuu_next;
        uoa_reg   <= uoa_next;
        atu_reg   <= atu_next;
        hx_reg    <= hx_next;
        ho_reg    <= ho_next;
        hoa_reg   <= hoa_next;
        r7_reg    <= r7_next;
    end

    // row select for the output word
    always_comb
    begin
        case (row_reg)
            2'd0:
            begin
                l0_w = lm_reg[0]; l1_w = lm_reg[1]; l2_w = lm_reg[2];
                r0_w = rm_reg[0]; r1_w = rm_reg[1]; r2_w = rm_reg[2];
            end
            2'd1:
            begin
                l0_w = lm_reg[3]; l1_w = lm_reg[4]; l2_w = lm_reg[5];
                r0_w = rm_reg[3]; r1_w = rm_reg[4]; r2_w = rm_reg[5];
            end
            default:
            begin
                l0_w = lm_reg[6]; l1_w = lm_reg[7]; l2_w = lm_reg[8];
                r0_w = rm_reg[6]; r1_w = rm_reg[7]; r2_w = rm_reg[8];
            end
        endcase
    end

    assign in_ready        = (state_reg == roe_avg_pkg::ST_IDLE);
    assign out_valid       = (state_reg == roe_avg_pkg::ST_OUT);
    assign row_index       = row_reg;
    assign last_row        = (row_reg == roe_avg_pkg::ROW_LAST);
    assign left_col0       = out_s32(l0_w);
    assign left_col1       = out_s32(l1_w);
    assign left_col2       = out_s32(l2_w);
    assign right_col0      = out_s32(r0_w);
    assign right_col1      = out_s32(r1_w);
    assign right_col2      = out_s32(r2_w);
    assign avg_density     = out_u31(avrho_reg);
    assign avg_enthalpy    = out_s32(avh_reg);
    assign avg_velocity    = out_s32(avu_reg);
    assign avg_sound_speed = out_u31(ava_reg);

    // checks
    `ROE_AVG_ASSERT_IMP(a_idle_no_out, in_ready, !out_valid, "row word while idle")
    `ROE_AVG_ASSERT_NXT(a_last_to_idle, out_valid && out_ready && last_row, in_ready, "not idle after last row")
    `ROE_AVG_ASSERT_NXT(a_load_silent, in_valid && in_ready && (command == roe_avg_pkg::CMD_LOAD), !out_valid, "load gave a row word")
    `ROE_AVG_ASSERT_IMP(a_one_launch, 1'b1, $onehot0(go_s), "two units launched at once")

endmodule

@@ verif/roe_average_eigenvectors_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roe_average_eigenvectors_unit_tb
// self-checking bench for the roe average eigenvector unit
// ----------------------------------------------------------------------------
// Cells are queued by a stimulus process and offered by a clocked driver
// with random gaps. Every accepted cell is run through a fixed point
// predictor that keeps its own copy of the stored left cell, both matrices
// and gamma; each pair queues its three expected row words. A clocked monitor
// compares each row word with the oldest expectation. Gamma is rewritten
// between phases while the unit is idle, and once the receiver holds off
// for a long stretch while cells keep coming.
// ----------------------------------------------------------------------------
module roe_average_eigenvectors_unit_tb;

    localparam int          FRAC      = 16;
    localparam longint      WMAX      = 64'sd2147483647;
    localparam longint      WMIN      = -64'sd2147483648;
    localparam longint      ONE       = 64'sd1 << FRAC;
    localparam longint      HALF      = 64'sd1 << (FRAC - 1);
    localparam longint      QUARTER   = 64'sd1 << (FRAC - 2);
    localparam int          IDLE_WAIT = 800;
    localparam longint      LIMIT     = 1000000;
    localparam int          LONG_HOLD = 3000;

    typedef struct {
        roe_avg_pkg::roe_avg_cmd_t cmd;
        logic [30:0]  rho;
        logic [31:0]  vel;
        logic [30:0]  prs;
        logic [30:0]  eng;
    } cell_t;

    typedef struct {
        logic [1:0]  row;
        logic [31:0] l0, l1, l2, r0, r1, r2;
        logic [30:0] arho;
        logic [31:0] ah, au;
        logic [30:0] aa;
        logic        last;
    } row_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [17:0] heat_word = roe_avg_pkg::HEAT_RATIO_RESET;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = roe_avg_pkg::CMD_LOAD;
    logic [30:0] density = 31'd1;
    logic [31:0] velocity = '0;
    logic [30:0] pressure = '0;
    logic [30:0] energy = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  row_index;
    logic [31:0] left_col0, left_col1, left_col2;
    logic [31:0] right_col0, right_col1, right_col2;
    logic [30:0] avg_density, avg_sound_speed;
    logic [31:0] avg_enthalpy, avg_velocity;
    logic        last_row;

    roe_average_eigenvectors_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .heat_ratio      (heat_word),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .density         (density),
        .velocity        (velocity),
        .pressure        (pressure),
        .energy          (energy),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .row_index       (row_index),
        .left_col0       (left_col0),
        .left_col1       (left_col1),
        .left_col2       (left_col2),
        .right_col0      (right_col0),
        .right_col1      (right_col1),
        .right_col2      (right_col2),
        .avg_density     (avg_density),
        .avg_enthalpy    (avg_enthalpy),
        .avg_velocity    (avg_velocity),
        .avg_sound_speed (avg_sound_speed),
        .last_row        (last_row)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: gamma, stored left cell, both matrices
    // ------------------------------------------------------------------
    longint    gamma_q;
    longint    left_sqrt, left_h, left_u;
    longint    lmat[9];
    longint    rmat[9];

    cell_t     cell_q[$];
    row_word_t row_q[$];

    int        mismatches = 0;
    int        cells_sent = 0;
    int        rows_seen = 0;
    int        sat_div_cells = 0;
    bit        no_gaps = 1'b0;
    int        hold_token = 0;

    // saturating fixed point helpers, 32-bit word
    function automatic longint sat(longint v);
        return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
    endfunction

    function automatic longint unsigned magn(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint signed_mag(bit neg, longint unsigned m);
        if (neg)
        begin
            return m > longint'(WMAX) + 1 ? WMIN : -longint'(m);
        end
        return m > longint'(WMAX) ? WMAX : longint'(m);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint unsigned p;
        p = (magn(a) * magn(b)) >> FRAC;
        return signed_mag((a < 0) != (b < 0), p);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        longint unsigned q;
        if (b == 0)
        begin
            return a < 0 ? WMIN : WMAX;
        end
        q = (magn(a) << FRAC) / magn(b);
        return signed_mag((a < 0) != (b < 0), q);
    endfunction

    function automatic longint fx_root(longint x);
        longint unsigned t;
        longint unsigned r;
        longint unsigned c;
        if (x <= 0)
        begin
            return 0;
        end
        t = longint'(x) << FRAC;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= t)
            begin
                r = c;
            end
        end
        return r > longint'(WMAX) ? WMAX : longint'(r);
    endfunction

    function automatic longint fx_add(longint a, longint b);
        return sat(a + b);
    endfunction

    function automatic longint fx_neg(longint a);
        return a == WMIN ? WMAX : -a;
    endfunction

    function automatic longint fx_sub(longint a, longint b);
        return fx_add(a, fx_neg(b));
    endfunction

    function automatic logic [30:0] to_u31(longint v);
        return v > WMAX ? 31'h7fffffff : (v < 0 ? 31'd0 : v[30:0]);
    endfunction

    // computes the roe pair for one accepted cell and queues its rows; a load only stores the left cell
    function automatic void roe_predict(cell_t c);
        longint rho, u, p, e, sr, h, s, d1, d2, arho, ah, au, gm1, aa;
        longint onea, xp, xpuu, xpu, uoa, atu;
        row_word_t w;
        rho = c.rho;
        u   = longint'($signed(c.vel));
        p   = c.prs;
        e   = c.eng;
        sr  = fx_root(rho);
        h   = fx_div(fx_add(e, p), rho);
        if (c.cmd == roe_avg_pkg::CMD_LOAD)
        begin
            left_sqrt = sr;
            left_h    = h;
            left_u    = u;
            return;
        end
        s    = fx_add(left_sqrt, sr);
        d1   = fx_div(left_sqrt, s);
        d2   = fx_div(sr, s);
        arho = fx_mul(fx_mul(s, s), QUARTER);
        ah   = fx_add(fx_mul(d1, left_h), fx_mul(d2, h));
        au   = fx_add(fx_mul(d1, left_u), fx_mul(d2, u));
        gm1  = fx_sub(gamma_q, ONE);
        aa   = fx_root(fx_mul(fx_sub(ah, fx_mul(HALF, fx_mul(au, au))), gm1));
        left_sqrt = sr;
        left_h    = h;
        left_u    = u;
        if (aa == 0)
        begin
            sat_div_cells++;
        end
        onea = fx_div(ONE, aa);
        xp   = fx_mul(fx_mul(fx_mul(HALF, gm1), onea), onea);
        xpuu = fx_mul(fx_mul(xp, au), au);
        xpu  = fx_mul(xp, au);
        uoa  = fx_div(au, aa);
        atu  = fx_mul(aa, au);
        if (c.cmd == roe_avg_pkg::CMD_OUTER || c.cmd == roe_avg_pkg::CMD_FULL)
        begin
            lmat[0] = fx_add(fx_mul(HALF, xpuu), fx_mul(HALF, uoa));
            lmat[1] = fx_sub(fx_neg(xpu), fx_mul(HALF, onea));
            lmat[2] = xp;
            lmat[6] = fx_sub(fx_mul(HALF, xpuu), fx_mul(HALF, uoa));
            lmat[7] = fx_add(fx_neg(xpu), fx_mul(HALF, onea));
            lmat[8] = xp;
            rmat[0] = ONE;
            rmat[2] = ONE;
            rmat[3] = fx_sub(au, aa);
            rmat[5] = fx_add(au, aa);
            rmat[6] = fx_sub(ah, atu);
            rmat[8] = fx_add(ah, atu);
        end
        if (c.cmd == roe_avg_pkg::CMD_MIDDLE || c.cmd == roe_avg_pkg::CMD_FULL)
        begin
            lmat[3] = fx_sub(ONE, xpuu);
            lmat[4] = fx_add(xpu, xpu);
            lmat[5] = fx_neg(fx_add(xp, xp));
        end
        if (c.cmd == roe_avg_pkg::CMD_FULL)
        begin
            rmat[1] = ONE;
            rmat[4] = au;
            rmat[7] = fx_mul(fx_mul(HALF, au), au);
        end
        for (int r = 0; r < 3; r++)
        begin
            w.row  = r[1:0];
            w.l0   = lmat[r*3][31:0];
            w.l1   = lmat[r*3+1][31:0];
            w.l2   = lmat[r*3+2][31:0];
            w.r0   = rmat[r*3][31:0];
            w.r1   = rmat[r*3+1][31:0];
            w.r2   = rmat[r*3+2][31:0];
            w.arho = to_u31(arho);
            w.ah   = ah[31:0];
            w.au   = au[31:0];
            w.aa   = to_u31(aa);
            w.last = (r[1:0] == roe_avg_pkg::ROW_LAST);
            row_q.push_back(w);
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if (no_gaps)
        begin
            return 0;
        end
        return $urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : $urandom_range(6, 40);
    endfunction

    // ------------------------------------------------------------------
    // input driver: changes at the falling edge
    // ------------------------------------------------------------------
    bit in_took = 1'b0;
    int in_gap = 0;

    always @(negedge clk)
    begin
        cell_t c;
        if (rst_n)
        begin
            if (in_valid && !in_took)
            begin
                // word still waiting, hold payload
            end
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (cell_q.size() > 0)
            begin
                c = cell_q.pop_front();
                command  <= c.cmd;
                density  <= c.rho;
                velocity <= c.vel;
                pressure <= c.prs;
                energy   <= c.eng;
                in_valid <= 1'b1;
                in_gap   <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver ready: random gaps plus one long hold-off on request
    // ------------------------------------------------------------------
    int out_gap = 0;
    int hold_cnt = 0;
    int hold_seen = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                hold_cnt  <= hold_cnt - 1;
                out_ready <= 1'b0;
            end
            else if (hold_seen != hold_token)
            begin
                hold_seen <= hold_token;
                hold_cnt  <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap   <= pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: accept input words, check row words at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cell_t     c;
        row_word_t x;
        in_took <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            c.cmd = roe_avg_pkg::roe_avg_cmd_t'(command);
            c.rho = density;
            c.vel = velocity;
            c.prs = pressure;
            c.eng = energy;
            roe_predict(c);
            cells_sent++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            rows_seen++;
            if (row_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected row word %0d at %0t", row_index, $realtime);
                end
            end
            else
            begin
                x = row_q.pop_front();
                if (row_index !== x.row || left_col0 !== x.l0 || left_col1 !== x.l1
                    || left_col2 !== x.l2 || right_col0 !== x.r0 || right_col1 !== x.r1
                    || right_col2 !== x.r2 || avg_density !== x.arho
                    || avg_enthalpy !== x.ah || avg_velocity !== x.au
                    || avg_sound_speed !== x.aa || last_row !== x.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("row mismatch at %0t", $realtime);
                        $display("  exp row %0d L %h %h %h R %h %h %h avg %h %h %h %h last %b",
                                 x.row, x.l0, x.l1, x.l2, x.r0, x.r1, x.r2,
                                 x.arho, x.ah, x.au, x.aa, x.last);
                        $display("  got row %0d L %h %h %h R %h %h %h avg %h %h %h %h last %b",
                                 row_index, left_col0, left_col1, left_col2,
                                 right_col0, right_col1, right_col2, avg_density,
                                 avg_enthalpy, avg_velocity, avg_sound_speed, last_row);
                    end
                end
            end
        end
    end

    // run limit in cycles
    longint cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d rows outstanding", cycles, row_q.size());
            $display("roe_average_eigenvectors_unit_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic add_cell(roe_avg_pkg::roe_avg_cmd_t cmd, logic [30:0] rho,
                            logic [31:0] vel, logic [30:0] prs, logic [30:0] eng);
        cell_t c;
        c.cmd = cmd;
        c.rho = rho;
        c.vel = vel;
        c.prs = prs;
        c.eng = eng;
        cell_q.push_back(c);
    endtask

    // random cell: mostly physical values, some raw bit patterns
    task automatic add_random_cell();
        roe_avg_pkg::roe_avg_cmd_t cmd;
        logic [30:0]  rho, prs, eng;
        logic [31:0]  vel;
        int           k;
        k   = $urandom_range(0, 99);
        cmd = k < 25 ? roe_avg_pkg::CMD_LOAD
                     : roe_avg_pkg::roe_avg_cmd_t'($urandom_range(1, 3));
        if ($urandom_range(0, 9) < 7)
        begin
            rho = 31'($urandom_range(16384, 10 * 65536));
            vel = 32'($urandom_range(0, 8 * 65536)) - 32'(4 * 65536);
            prs = 31'($urandom_range(0, 10 * 65536));
            eng = 31'(prs * 3 + $urandom_range(0, 20 * 65536));
        end
        else
        begin
            rho = 31'($urandom());
            vel = $urandom();
            prs = 31'($urandom());
            eng = 31'($urandom());
            if (rho == 0)
            begin
                rho = 31'd1;
            end
        end
        add_cell(cmd, rho, vel, prs, eng);
    endtask

    task automatic write_gamma(logic [17:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        heat_word <= v;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        gamma_q = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (cell_q.size() > 0 || in_valid || row_q.size() > 0)
        begin
            @(posedge clk);
        end
        // a trailing load word gives no row, let it finish
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    initial
    begin
        logic [17:0] g;
        gamma_q   = roe_avg_pkg::HEAT_RATIO_RESET;
        left_sqrt = 0;
        left_h    = 0;
        left_u    = 0;
        for (int i = 0; i < 9; i++)
        begin
            lmat[i] = 0;
            rmat[i] = 0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: pair before any load, then the field extremes
        add_cell(roe_avg_pkg::CMD_FULL,   31'd65536, 32'd0, 31'd65536, 31'd163840);
        add_cell(roe_avg_pkg::CMD_LOAD,   31'd65536, 32'd65536, 31'd65536, 31'd196608);
        add_cell(roe_avg_pkg::CMD_OUTER,  31'd8192, 32'hffff0000, 31'd6554, 31'd20000);
        add_cell(roe_avg_pkg::CMD_MIDDLE, 31'd131072, 32'd32768, 31'd131072, 31'd400000);
        add_cell(roe_avg_pkg::CMD_FULL,   31'd65536, 32'd0, 31'd65536, 31'd163840);
        add_cell(roe_avg_pkg::CMD_FULL,   31'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                 31'h7fffffff);
        add_cell(roe_avg_pkg::CMD_FULL,   31'd1, 32'h80000000, 31'd0, 31'd0);
        add_cell(roe_avg_pkg::CMD_OUTER,  31'd1, 32'h7fffffff, 31'h7fffffff, 31'd0);
        add_cell(roe_avg_pkg::CMD_LOAD,   31'h7fffffff, 32'h80000000, 31'd0, 31'h7fffffff);
        add_cell(roe_avg_pkg::CMD_MIDDLE, 31'd1, 32'd0, 31'd0, 31'd0);
        // velocity too large for the enthalpy: sound speed clamps to zero
        add_cell(roe_avg_pkg::CMD_LOAD,   31'd65536, 32'd10 << 16, 31'd65536, 31'd65536);
        add_cell(roe_avg_pkg::CMD_FULL,   31'd65536, 32'd10 << 16, 31'd65536, 31'd65536);
        add_cell(roe_avg_pkg::CMD_OUTER,  31'd65536, -32'sd655360, 31'd65536, 31'd65536);
        add_cell(roe_avg_pkg::CMD_MIDDLE, 31'd65536, 32'd12 << 16, 31'd0, 31'd1);
        add_cell(roe_avg_pkg::CMD_LOAD,   31'h2aaaaaaa, 32'h55555555, 31'h55555555,
                 31'h2aaaaaaa);
        add_cell(roe_avg_pkg::CMD_FULL,   31'h55555555, 32'haaaaaaaa, 31'h2aaaaaaa,
                 31'h55555555);
        add_cell(roe_avg_pkg::CMD_OUTER,  31'd65536, 32'd0, 31'd0, 31'd0);
        add_cell(roe_avg_pkg::CMD_FULL,   31'd32768, 32'd98304, 31'd40000, 31'd200000);
        drain();

        // random phases, each under another gamma, extremes included
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: g = 18'd65537;
                1: g = 18'd196608;
                2: g = 18'($urandom_range(65537, 196608));
                3: g = roe_avg_pkg::HEAT_RATIO_RESET;
                default: g = 18'($urandom_range(65537, 196608));
            endcase
            write_gamma(g);
            no_gaps = (ph == 3);
            for (int i = 0; i < 36; i++)
            begin
                add_random_cell();
            end
            if (ph == 2)
            begin
                // receiver holds off while the sender keeps offering cells
                hold_token = hold_token + 1;
            end
            drain();
        end

        $display("cells accepted %0d, row words checked %0d, zero sound speed pairs %0d",
                 cells_sent, rows_seen, sat_div_cells);
        $display("gamma written over five settings incl. both range ends, one long stall");
        if (mismatches == 0)
        begin
            $display("roe_average_eigenvectors_unit_tb OK");
        end
        else
        begin
            $display("mismatches: %0d", mismatches);
            $display("roe_average_eigenvectors_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
